// File: hdl/ahc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address hit counter package
// Shared constants and types for the address hit counter with top-K report.
// ----------------------------------------------------------------------------
package ahc_pkg;
	localparam int unsigned TableEntries = 1024;
	localparam int unsigned TopK         = 10;
	localparam int unsigned IdxW         = $clog2(TableEntries);
	localparam int unsigned CntW         = IdxW + 1;
	localparam int unsigned RankW        = 4;
	localparam int unsigned AddrW        = 64;
	localparam int unsigned HitW         = 32;
	localparam int unsigned LimitW       = 11;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [AddrW-1:0] address;
	} ahc_in_t;

	typedef struct packed {
		logic             entry_valid;
		logic [9:0]       entry_index;
		logic [AddrW-1:0] entry_address;
		logic [HitW-1:0]  hit_total;
		logic             newly_added;
		logic             dropped_full;
		logic [RankW-1:0] rank;
		logic             is_last;
	} ahc_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REC_RD,
		ST_REC_CMP,
		ST_REC_HIT,
		ST_REC_MISS,
		ST_REP_INIT,
		ST_REP_RD,
		ST_REP_CMP,
		ST_REP_EMIT,
		ST_REP_EMPTY,
		ST_OUT
	} ahc_state_t;
endpackage

// File: hdl/ahc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address hit counter channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ahc_in_if;
	import ahc_pkg::*;
	logic    valid;
	logic    ready;
	ahc_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ahc_out_if;
	import ahc_pkg::*;
	logic     valid;
	logic     ready;
	ahc_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/ahc_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address hit counter table
// Slot address and hit count memories, one read and one write port, registered read.
// ----------------------------------------------------------------------------
module ahc_table (
	input  logic                       clk,
	input  logic [ahc_pkg::IdxW-1:0]  rd_idx,
	output logic [ahc_pkg::AddrW-1:0] rd_addr,
	output logic [ahc_pkg::HitW-1:0]  rd_hits,
	input  logic                       wr_en,
	input  logic [ahc_pkg::IdxW-1:0]  wr_idx,
	input  logic [ahc_pkg::AddrW-1:0] wr_addr,
	input  logic [ahc_pkg::HitW-1:0]  wr_hits
);
	import ahc_pkg::*;
	logic [AddrW-1:0] addr_mem [TableEntries];
	logic [HitW-1:0]  hits_mem [TableEntries];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= wr_addr;
			hits_mem[wr_idx] <= wr_hits;
		end
		rd_addr <= addr_mem[rd_idx];
		rd_hits <= hits_mem[rd_idx];
	end
endmodule

// File: hdl/address_hit_counter_top_k.sv
`timescale 1ns / 1ps
// A record item sweeps the filled slots through the read and compare states
// and ends in a hit update, a new slot or a drop; a report item spends one
// setup state and then sweeps all N filled slots for each of its min(K,N)
// results. Only one item is in work at a time: the input is ready again
// after its last result is taken; the single table read port sets the pace.
// Reset clears the fill count and sets the limit register to 1024.
// ----------------------------------------------------------------------------
// Address hit counter top level
// Sequencer that sweeps the slot table for record and top-K report items.
// ----------------------------------------------------------------------------
module address_hit_counter_top_k (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [ahc_pkg::LimitW-1:0] cfg_wdata,
	ahc_in_if.sink                      in_ch,
	ahc_out_if.source                   out_ch
);
	import ahc_pkg::*;

	ahc_state_t state_q, state_d;
	logic [LimitW-1:0] limit_q;
	logic [CntW-1:0]   used_q;
	logic [CntW-1:0]   scan_q;
	logic [AddrW-1:0]  addr_q;
	logic              cmd_q;
	logic [RankW-1:0]  rank_q;
	logic [RankW-1:0]  count_q;
	logic              found_q;
	logic [IdxW-1:0]   best_q;
	logic [HitW-1:0]   best_hits_q;
	logic [AddrW-1:0]  best_addr_q;
	logic [IdxW-1:0]   prev_idx_q;
	logic [HitW-1:0]   prev_hits_q;
	ahc_out_t          res_q;
	logic              out_v_q;

	logic [IdxW-1:0]   rd_idx;
	logic [AddrW-1:0]  rd_addr;
	logic [HitW-1:0]   rd_hits;
	logic              wr_en;
	logic [IdxW-1:0]   wr_idx;
	logic [HitW-1:0]   wr_hits;
	logic [CntW-1:0]   eff_limit;
	logic [CntW-1:0]   scan_idx_m1;
	logic              eligible;

	ahc_table u_table (
		.clk(clk), .rd_idx(rd_idx), .rd_addr(rd_addr), .rd_hits(rd_hits),
		.wr_en(wr_en), .wr_idx(wr_idx), .wr_addr(addr_q), .wr_hits(wr_hits)
	);

	assign eff_limit = (limit_q > LimitW'(TableEntries)) ? CntW'(TableEntries)
		: CntW'(limit_q);
	// While comparing, the matched slot is read again so its count is at hand.
	assign rd_idx = (state_q == ST_REC_CMP) ? scan_idx_m1[IdxW-1:0] : scan_q[IdxW-1:0];
	assign scan_idx_m1 = scan_q - 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data = res_q;

	// A slot is still unreported when it ranks below the last one handed out:
	// a lower count, or an equal count in a later slot.
	assign eligible = (rank_q == '0) || (rd_hits < prev_hits_q) ||
		(rd_hits == prev_hits_q && scan_idx_m1[IdxW-1:0] > prev_idx_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) begin
				state_d = (in_ch.data.cmd == CMD_REPORT) ? ST_REP_INIT : ST_REC_RD;
			end
			ST_REC_RD: state_d = (scan_q >= used_q) ? ST_REC_MISS : ST_REC_CMP;
			ST_REC_CMP: state_d = (rd_addr == addr_q) ? ST_REC_HIT : ST_REC_RD;
			ST_REC_HIT: state_d = ST_OUT;
			ST_REC_MISS: state_d = ST_OUT;
			ST_REP_INIT: state_d = (used_q == '0) ? ST_REP_EMPTY : ST_REP_RD;
			ST_REP_RD: state_d = (scan_q >= used_q) ? ST_REP_EMIT : ST_REP_CMP;
			ST_REP_CMP: state_d = ST_REP_RD;
			ST_REP_EMIT: state_d = ST_OUT;
			ST_REP_EMPTY: state_d = ST_OUT;
			ST_OUT: if (!out_v_q) begin
				state_d = (cmd_q == CMD_REPORT && !res_q.is_last) ? ST_REP_RD : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_idx = scan_q[IdxW-1:0];
		wr_hits = 32'd1;
		unique case (state_q)
			ST_REC_HIT: begin
				wr_en = 1'b1;
				wr_idx = scan_idx_m1[IdxW-1:0];
				wr_hits = (rd_hits == '1) ? rd_hits : rd_hits + 1'b1;
			end
			ST_REC_MISS: begin
				wr_en = (used_q < eff_limit);
				wr_idx = used_q[IdxW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LimitW'(1024);
			used_q <= '0;
			scan_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) limit_q <= cfg_wdata;
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					addr_q <= in_ch.data.address;
					cmd_q <= in_ch.data.cmd;
					scan_q <= '0;
					rank_q <= '0;
				end
				ST_REC_RD: scan_q <= scan_q + 1'b1;
				ST_REC_HIT: begin
					res_q <= '{1'b1, 10'(scan_idx_m1[IdxW-1:0]), addr_q, wr_hits,
						1'b0, 1'b0, '0, 1'b1};
					out_v_q <= 1'b1;
				end
				ST_REC_MISS: begin
					if (used_q < eff_limit) begin
						used_q <= used_q + 1'b1;
						res_q <= '{1'b1, 10'(used_q[IdxW-1:0]), addr_q, 32'd1,
							1'b1, 1'b0, '0, 1'b1};
					end else begin
						res_q <= '{1'b0, 10'd0, 64'd0, 32'd0, 1'b0, 1'b1, '0, 1'b1};
					end
					out_v_q <= 1'b1;
				end
				ST_REP_INIT: begin
					found_q <= 1'b0;
					count_q <= (used_q < CntW'(TopK)) ? RankW'(used_q) : RankW'(TopK);
				end
				ST_REP_RD: scan_q <= scan_q + 1'b1;
				ST_REP_CMP: begin
					if (eligible && (!found_q || rd_hits > best_hits_q)) begin
						found_q <= 1'b1;
						best_q <= scan_idx_m1[IdxW-1:0];
						best_hits_q <= rd_hits;
						best_addr_q <= rd_addr;
					end
				end
				ST_REP_EMIT: begin
					prev_idx_q <= best_q;
					prev_hits_q <= best_hits_q;
					res_q <= '{1'b1, 10'(best_q), best_addr_q, best_hits_q,
						1'b0, 1'b0, rank_q, (rank_q + 1'b1 == count_q)};
					out_v_q <= 1'b1;
					rank_q <= rank_q + 1'b1;
					scan_q <= '0;
					found_q <= 1'b0;
				end
				ST_REP_EMPTY: begin
					res_q <= '{1'b0, 10'd0, 64'd0, 32'd0, 1'b0, 1'b0, '0, 1'b1};
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: tb/ahc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address hit counter checker
// Watches both channels and the limit register writes. Keeps its own copy of
// the slot table, works out the results of every accepted item, and compares
// each accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module ahc_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ahc_pkg::LimitW-1:0] cfg_wdata,
	ahc_in_if                          in_ch,
	ahc_out_if                         out_ch,
	output int                         fail_count,
	output int                         outstanding
);
	import ahc_pkg::*;

	localparam logic [HitW-1:0] HitMax = '1;

	logic [AddrW-1:0]  table_addr [TableEntries];
	logic [HitW-1:0]   table_hits [TableEntries];
	int unsigned       fill;
	logic [LimitW-1:0] limit_reg;
	ahc_out_t          expected_results [$];

	assign outstanding = expected_results.size();

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h, wanted %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic ahc_out_t blank_result();
		ahc_out_t r;
		r = '0;
		return r;
	endfunction

	task automatic predict_item(input ahc_in_t item);
		ahc_out_t    r;
		int unsigned lim;
		int unsigned count;
		int          best;
		bit          taken [TableEntries];
		bit          hit;
		lim = (limit_reg < TableEntries) ? limit_reg : TableEntries;
		r   = blank_result();
		r.is_last = 1'b1;
		if (item.cmd == CMD_RECORD) begin
			hit = 0;
			for (int i = 0; i < fill; i++) begin
				if (!hit && table_addr[i] == item.address) begin
					hit = 1;
					if (table_hits[i] != HitMax) table_hits[i]++;
					r.entry_valid   = 1'b1;
					r.entry_index   = i[9:0];
					r.entry_address = item.address;
					r.hit_total     = table_hits[i];
				end
			end
			if (!hit && fill < lim) begin
				table_addr[fill] = item.address;
				table_hits[fill] = 1;
				r.entry_valid   = 1'b1;
				r.entry_index   = fill[9:0];
				r.entry_address = item.address;
				r.hit_total     = 1;
				r.newly_added   = 1'b1;
				fill++;
			end else if (!hit) begin
				r.dropped_full = 1'b1;
			end
			expected_results.push_back(r);
		end else begin
			count = (fill < TopK) ? fill : TopK;
			if (count == 0) begin
				expected_results.push_back(r);
			end else begin
				for (int k = 0; k < count; k++) begin
					best = -1;
					// Strictly greater keeps the earlier slot ahead on equal counts.
					for (int i = 0; i < fill; i++) begin
						if (!taken[i] && (best < 0 || table_hits[i] > table_hits[best]))
							best = i;
					end
					taken[best] = 1;
					r = blank_result();
					r.entry_valid   = 1'b1;
					r.entry_index   = best[9:0];
					r.entry_address = table_addr[best];
					r.hit_total     = table_hits[best];
					r.rank          = k[RankW-1:0];
					r.is_last       = (k + 1 == count);
					expected_results.push_back(r);
				end
			end
		end
	endtask

	task automatic compare_result(input ahc_out_t got);
		ahc_out_t want;
		if (expected_results.size() == 0) begin
			$display("mismatch at %0t: result with nothing outstanding", $realtime);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		if (got.entry_valid !== want.entry_valid)
			report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
		if (got.entry_index !== want.entry_index)
			report_mismatch("entry_index", got.entry_index, want.entry_index);
		if (got.entry_address !== want.entry_address)
			report_mismatch("entry_address", got.entry_address, want.entry_address);
		if (got.hit_total !== want.hit_total)
			report_mismatch("hit_total", got.hit_total, want.hit_total);
		if (got.newly_added !== want.newly_added)
			report_mismatch("newly_added", got.newly_added, want.newly_added);
		if (got.dropped_full !== want.dropped_full)
			report_mismatch("dropped_full", got.dropped_full, want.dropped_full);
		if (got.rank !== want.rank)
			report_mismatch("rank", got.rank, want.rank);
		if (got.is_last !== want.is_last)
			report_mismatch("is_last", got.is_last, want.is_last);
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill      <= 0;
			limit_reg <= LimitW'(TableEntries);
			expected_results.delete();
		end else begin
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) compare_result(out_ch.data);
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) predict_item(in_ch.data);
			if (cfg_we) limit_reg <= cfg_wdata;
		end
	end
endmodule

// File: tb/tb_address_hit_counter_top_k.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address hit counter testbench
// Drives record and report items through several table limits, first a
// directed set and then random phases drawn from a reused address pool, with
// random idling on both sides and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_address_hit_counter_top_k;
	import ahc_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LimitW-1:0] cfg_wdata;
	int                fail_count;
	int                outstanding;
	bit                calm;
	bit                hold_go;
	int                hold_left;
	bit                hold_done;
	logic [AddrW-1:0]  addr_pool [$];

	ahc_in_if  in_ch ();
	ahc_out_if out_ch ();

	address_hit_counter_top_k u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	ahc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls, except for one long hold-off when asked.
	initial begin
		out_ch.ready = 1'b0;
		hold_left    = 0;
		hold_done    = 0;
	end
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left    <= 400;
			hold_done    <= 1;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
		end
	end

	task automatic send_item(input logic cmd, input logic [AddrW-1:0] address);
		if (!calm) begin
			while ($urandom_range(99) < 27) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_ch.valid        <= 1'b1;
		in_ch.data.cmd     <= cmd;
		in_ch.data.address <= address;
		@(negedge clk);
		while (in_ch.ready !== 1'b1) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [LimitW-1:0] value);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int items);
		logic [AddrW-1:0] a;
		for (int n = 0; n < items; n++) begin
			if ($urandom_range(99) < 15) begin
				send_item(CMD_REPORT, {$urandom, $urandom});
			end else begin
				if (addr_pool.size() > 0 && $urandom_range(99) < 85) begin
					a = addr_pool[$urandom_range(addr_pool.size() - 1)];
				end else begin
					a = {$urandom, $urandom};
					addr_pool.push_back(a);
				end
				send_item(CMD_RECORD, a);
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		calm        = 0;
		hold_go     = 0;
		arst_n      = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A one-slot table: empty report, hit, and a drop once full.
		set_limit(1);
		send_item(CMD_REPORT, '0);
		send_item(CMD_RECORD, '0);
		send_item(CMD_RECORD, '0);
		send_item(CMD_RECORD, '1);
		send_item(CMD_REPORT, '1);
		// Limit below the fill: existing slots still count, new ones drop.
		set_limit(0);
		send_item(CMD_RECORD, 64'h5555_5555_5555_5555);
		send_item(CMD_RECORD, '0);
		send_item(CMD_REPORT, '0);
		// Top of the register range clamps to the table size.
		set_limit(2047);
		send_item(CMD_RECORD, '1);
		send_item(CMD_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(CMD_RECORD, 64'h5555_5555_5555_5555);
		send_item(CMD_RECORD, '1);
		send_item(CMD_RECORD, 64'h8000_0000_0000_0001);
		send_item(CMD_REPORT, '0);
		addr_pool.push_back('0);
		addr_pool.push_back('1);
		addr_pool.push_back(64'hAAAA_AAAA_AAAA_AAAA);

		set_limit(12);
		random_phase(90);
		set_limit(1024);
		calm = 1;
		random_phase(90);
		calm = 0;
		set_limit(20);
		hold_go = 1;
		random_phase(90);
		set_limit(2047);
		random_phase(90);
		set_limit(45);
		random_phase(90);

		in_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#50ms;
		$display("status: fail");
		$finish;
	end
endmodule
